// File: src/acmac_pkg.sv
// package: aes tables, block helpers and the queue entry type
package acmac_pkg;

  localparam int BlockW = 128;
  localparam int HalfW = 64;
  localparam int QueueDepth = 4;
  localparam int Rounds = 10;

  // queue entry: one block to encrypt and what to do with it
  typedef enum logic [1:0] {
    OP_CHAIN = 2'd0,
    OP_FINAL = 2'd1,
    OP_EMPTY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [BlockW-1:0]   blk;
    logic                use_k1;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block, byte zero at the top
  function automatic logic [7:0] byte_of(input logic [BlockW-1:0] v, input int i);
    return v[BlockW-1-8*i -: 8];
  endfunction

  // one round less the key addition: subbytes, shiftrows, optional mixcolumns
  function automatic logic [BlockW-1:0] aes_round(input logic [BlockW-1:0] s,
                                                  input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [BlockW-1:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r+4*c] = sbox(byte_of(s, r + 4*((c+r)%4)));
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++)
      o[BlockW-1-8*i -: 8] = t[i];
    return o;
  endfunction

  // next round key from the previous one
  function automatic logic [BlockW-1:0] next_key(input logic [BlockW-1:0] k,
                                                 input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, g;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    g = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [BlockW-1:0] dbl(input logic [BlockW-1:0] v);
    return {v[BlockW-2:0], 1'b0} ^ (v[BlockW-1] ? 128'h87 : 128'h0);
  endfunction

endpackage

// File: src/acmac_front.sv
// front end: gathers bytes into blocks and queues block jobs
module acmac_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                empty_message,
  output acmac_pkg::job_t     job,
  output logic                job_push,
  input  logic                job_full
);
  import acmac_pkg::*;

  logic [BlockW-1:0] buffer;
  logic [3:0]        count;
  logic [BlockW-1:0] merged;
  logic              take;

  assign in_stall = job_full;
  assign take = in_valid && !in_stall;

  // insert the byte and, for a short final block, the pad marker
  always_comb begin
    merged = buffer;
    merged[BlockW-1-8*count -: 8] = data_byte;
    if (last_byte && count != 4'd15)
      merged[BlockW-1-8*(count+5'd1) -: 8] = 8'h80;
  end

  always_comb begin
    job = '{op: OP_NONE, blk: merged, use_k1: (count == 4'd15)};
    job_push = 1'b0;
    if (take) begin
      if (empty_message) begin
        job.op = OP_EMPTY;
        job.blk = {8'h80, 120'h0};
        job.use_k1 = 1'b0;
        job_push = 1'b1;
      end else if (last_byte) begin
        job.op = OP_FINAL;
        job_push = 1'b1;
      end else if (count == 4'd15) begin
        job.op = OP_CHAIN;
        job_push = 1'b1;
      end
    end
  end

  // block gathering
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      buffer <= '0;
    end else if (take) begin
      if (empty_message || last_byte || count == 4'd15) begin
        count <= '0;
        buffer <= '0;
      end else begin
        count <= count + 4'd1;
        buffer <= merged;
      end
    end
  end

endmodule

// File: src/acmac_queue.sv
// small fifo of block jobs between front and back
module acmac_queue #(
  parameter int Depth = acmac_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  acmac_pkg::job_t wdata,
  output logic            full,
  input  logic            pop,
  output acmac_pkg::job_t rdata,
  output logic            not_empty
);
  import acmac_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem [Depth];
  logic [AW-1:0]   wptr, rptr;
  logic [AW:0]     fill;

  assign full = (fill == (AW+1)'(Depth));
  assign not_empty = (fill != '0);
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full)
        wptr <= (wptr == AW'(Depth-1)) ? '0 : wptr + 1'b1;
      if (pop && not_empty)
        rptr <= (rptr == AW'(Depth-1)) ? '0 : rptr + 1'b1;
      fill <= fill + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !not_empty == 1'b0)
    else $error("queue full yet empty");
  assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(fill))
    else $error("fill moved without traffic");
  assert property (@(posedge clk) disable iff (rst) fill <= (AW+1)'(Depth))
    else $error("fill beyond depth");

endmodule

// File: src/acmac_back.sv
// back end: round-per-cycle aes, subkeys, chaining and tag register
module acmac_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [127:0]        key,
  input  logic                key_write,
  input  acmac_pkg::job_t     job,
  input  logic                job_valid,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         mac_upper,
  output logic [63:0]         mac_lower
);
  import acmac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state;
  logic [3:0]        round;
  logic [BlockW-1:0] s, rk, k1, k2, chain, kin;
  logic [7:0]        rc;
  logic              ready_keys, doing_keys;
  op_t               cur_op;
  logic [BlockW-1:0] start_blk, rnd_out, next_rk;
  logic [BlockW-1:0] tag;
  logic              tag_full;

  assign kin = key;
  assign next_rk = next_key(rk, rc);
  assign rnd_out = aes_round(s, round != 4'(Rounds)) ^ next_rk;

  // block fed into the cipher for the job at the head of the queue
  always_comb begin
    start_blk = job.blk ^ (job.use_k1 ? k1 : k2);
    if (job.op == OP_CHAIN) start_blk = job.blk ^ chain;
    else if (job.op == OP_FINAL) start_blk = start_blk ^ chain;
  end

  assign job_pop = (state == ST_IDLE) && job_valid && ready_keys && !key_write
                   && !(tag_full && job.op != OP_CHAIN);

  // encryption sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ready_keys <= 1'b0;
      doing_keys <= 1'b0;
      chain <= '0;
      k1 <= '0;
      k2 <= '0;
      round <= '0;
      rc <= 8'h01;
      cur_op <= OP_NONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (key_write) ready_keys <= 1'b0;
          else if (!ready_keys) begin
            s <= kin ^ '0;
            rk <= kin;
            rc <= 8'h01;
            round <= 4'd1;
            doing_keys <= 1'b1;
            state <= ST_RUN;
          end else if (job_pop) begin
            s <= start_blk ^ kin;
            rk <= kin;
            rc <= 8'h01;
            round <= 4'd1;
            cur_op <= job.op;
            doing_keys <= 1'b0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (key_write) ready_keys <= 1'b0;
          // a new key abandons a subkey run under the old one
          if (key_write && doing_keys) state <= ST_IDLE;
          else begin
            s <= rnd_out;
            rk <= next_rk;
            rc <= xtime(rc);
            round <= round + 4'd1;
            if (round == 4'(Rounds)) state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
          if (doing_keys) begin
            k1 <= dbl(s);
            k2 <= dbl(dbl(s));
            ready_keys <= !key_write;
          end else begin
            if (key_write) ready_keys <= 1'b0;
            if (cur_op == OP_CHAIN) chain <= s;
            else chain <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // tag output register
  always_ff @(posedge clk) begin
    if (rst) tag_full <= 1'b0;
    else begin
      if (tag_full && !out_stall) tag_full <= 1'b0;
      if (state == ST_DONE && !doing_keys && cur_op != OP_CHAIN) begin
        tag_full <= 1'b1;
        tag <= s;
      end
    end
  end

  assign out_valid = tag_full;
  assign mac_upper = tag[127:64];
  assign mac_lower = tag[63:0];

  assert property (@(posedge clk) disable iff (rst) job_pop |-> ready_keys)
    else $error("job started without subkeys");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !doing_keys && cur_op != OP_CHAIN) |-> !tag_full || !out_stall)
    else $error("tag overwritten while held");
  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

endmodule

// File: src/aes_cmac_tag_engine.sv
// top level: aes-128 cmac tag engine
//  channel  direction  handshake         word
//  in       input      in_valid/in_stall    data_byte, last_byte, empty_message
//  out      output     out_valid/out_stall  mac_upper, mac_lower
//  cfg      input      cfg_we               cfg_index, cfg_data
// one byte a cycle while in_stall is low; each block runs through the round-per-cycle aes core.
// the job queue absorbs a block's work, so steady bytes flow at one a cycle unless it fills.
// after reset or a key write the subkeys are derived before any job starts.
// the tag appears once the last block is encrypted and holds while out_stall.
module aes_cmac_tag_engine #(
  parameter int QDepth = acmac_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] mac_upper,
  output logic [63:0] mac_lower,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import acmac_pkg::*;

  localparam logic RegKeyUpper = 1'b0;

  logic [63:0] key_upper, key_lower;
  job_t        fjob, qjob;
  logic        fpush, qfull, qpop, qne;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegKeyUpper) key_upper <= cfg_data;
      else key_lower <= cfg_data;
    end
  end

  acmac_front u_front (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .last_byte, .empty_message,
    .job(fjob), .job_push(fpush), .job_full(qfull)
  );

  acmac_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst, .push(fpush), .wdata(fjob), .full(qfull),
    .pop(qpop), .rdata(qjob), .not_empty(qne)
  );

  acmac_back u_back (
    .clk, .rst, .key({key_upper, key_lower}), .key_write(cfg_we),
    .job(qjob), .job_valid(qne), .job_pop(qpop),
    .out_valid, .out_stall, .mac_upper, .mac_lower
  );

endmodule
